// ----- src/bracket_balance_checker_assert.svh -----
// Assertion macros shared by the bracket balance checker's checker module
`ifndef BRACKET_BALANCE_CHECKER_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted
`define BBC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bracket balance check failed");

// Next-cycle implication, masked while reset is asserted
`define BBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bracket balance check failed");

// Next-cycle implication, live through reset
`define BBC_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("bracket balance reset check failed");

`endif

// ----- src/bbc_pkg.sv -----
// Shared types and constants for the bracket balance checker
package bbc_pkg;

    localparam int DEPTH_BITS = 16;
    localparam int LINE_BITS  = 24;
    localparam int COL_BITS   = 16;
    localparam int KIND_BITS  = 4;
    localparam int NUM_KINDS  = 9;

    // Character codes
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;

    // Report kinds, in delivery order
    typedef enum logic [KIND_BITS-1:0] {
        KIND_CLOSE_BRACE   = 4'd0,
        KIND_CLOSE_BRACKET = 4'd1,
        KIND_CLOSE_PAREN   = 4'd2,
        KIND_OPEN_BRACE    = 4'd3,
        KIND_OPEN_BRACKET  = 4'd4,
        KIND_OPEN_PAREN    = 4'd5,
        KIND_OPEN_STRING   = 4'd6,
        KIND_OPEN_COMMENT  = 4'd7,
        KIND_SUMMARY       = 4'd8
    } t_kind;

    typedef logic [NUM_KINDS-1:0] t_kind_mask;

    // All reports caused by one beat, sharing line and column
    typedef struct packed {
        t_kind_mask            mask;
        logic [LINE_BITS-1:0]  line;
        logic [COL_BITS-1:0]   col;
        logic                  conforms;
    } t_report;

endpackage

// ----- src/bbc_scan.sv -----
// Per-byte lexer state, depth counters and report set for one input beat
module bbc_scan
    import bbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output t_report    o_report
);

    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic [LINE_BITS-1:0]         LINE_MAX  = '1;
    localparam logic [COL_BITS-1:0]          COL_MAX   = '1;
    localparam logic [LINE_BITS-1:0]         LINE_ONE  = LINE_BITS'(1);

    logic signed [DEPTH_BITS-1:0] r_brace, r_bracket, r_paren;
    logic signed [DEPTH_BITS-1:0] n_brace, n_bracket, n_paren;
    logic                         r_str, r_lc, r_bc, r_slash, r_star, r_err;
    logic                         n_str, n_lc, n_bc, n_slash, n_star, n_err;
    logic [7:0]                   r_prev;
    logic [LINE_BITS-1:0]         r_line, n_line;
    logic [COL_BITS-1:0]          r_col, n_col;

    logic                         done;
    logic [2:0]                   closer_bad;
    logic [5:0]                   open_bad;
    logic [7:0]                   b;

    assign b = i_text_byte;

    // Advance line and column, saturating
    always_comb begin
        if (b == CH_NEWLINE) begin
            n_line = (r_line != LINE_MAX) ? r_line + LINE_ONE : r_line;
            n_col  = '0;
        end else begin
            n_line = r_line;
            n_col  = (r_col != COL_MAX) ? r_col + COL_BITS'(1) : r_col;
        end
    end

    // Lexer: comments, strings, held slash/star, depth tracking
    always_comb begin
        n_str      = r_str;
        n_lc       = r_lc;
        n_bc       = r_bc;
        n_slash    = r_slash;
        n_star     = r_star;
        n_brace    = r_brace;
        n_bracket  = r_bracket;
        n_paren    = r_paren;
        closer_bad = 3'b000;
        done       = 1'b0;

        // Resolve held lookahead flags
        if (r_slash) begin
            n_slash = 1'b0;
            if (b == CH_SLASH) begin
                n_lc = 1'b1;
                done = 1'b1;
            end else if (b == CH_STAR) begin
                n_bc = 1'b1;
                done = 1'b1;
            end
        end else if (r_star) begin
            n_star = 1'b0;
            if (b == CH_SLASH) begin
                n_bc = 1'b0;
                done = 1'b1;
            end
        end

        if (!done) begin
            if (b == CH_NEWLINE) begin
                n_lc = 1'b0;
            end else if (r_lc) begin
                n_lc = 1'b1;
            end else if (r_bc) begin
                if (b == CH_STAR) begin
                    n_star = 1'b1;
                end
            end else if (b == CH_QUOTE && !r_str) begin
                n_str = 1'b1;
            end else if (b == CH_QUOTE && r_prev != CH_BACKSLASH) begin
                n_str = 1'b0;
            end else if (!r_str) begin
                case (b)
                    CH_SLASH: n_slash = 1'b1;
                    CH_LBRACE: begin
                        if (r_brace != DEPTH_MAX) n_brace = r_brace + DEPTH_BITS'(1);
                    end
                    CH_LBRACKET: begin
                        if (r_bracket != DEPTH_MAX) n_bracket = r_bracket + DEPTH_BITS'(1);
                    end
                    CH_LPAREN: begin
                        if (r_paren != DEPTH_MAX) n_paren = r_paren + DEPTH_BITS'(1);
                    end
                    CH_RBRACE: begin
                        if (r_brace != DEPTH_MIN) n_brace = r_brace - DEPTH_BITS'(1);
                        closer_bad[0] = n_brace[DEPTH_BITS-1];
                    end
                    CH_RBRACKET: begin
                        if (r_bracket != DEPTH_MIN) n_bracket = r_bracket - DEPTH_BITS'(1);
                        closer_bad[1] = n_bracket[DEPTH_BITS-1];
                    end
                    CH_RPAREN: begin
                        if (r_paren != DEPTH_MIN) n_paren = r_paren - DEPTH_BITS'(1);
                        closer_bad[2] = n_paren[DEPTH_BITS-1];
                    end
                    default: ;
                endcase
            end
        end
    end

    // End-of-text checks on the state left after this byte
    always_comb begin
        n_err       = r_err | (|closer_bad);
        open_bad[0] = !n_brace[DEPTH_BITS-1]   && (n_brace != '0);
        open_bad[1] = !n_bracket[DEPTH_BITS-1] && (n_bracket != '0);
        open_bad[2] = !n_paren[DEPTH_BITS-1]   && (n_paren != '0);
        open_bad[3] = n_str;
        open_bad[4] = n_bc;
        open_bad[5] = 1'b1;

        o_report.line     = n_line;
        o_report.col      = n_col;
        o_report.conforms = !(n_err | (|open_bad[4:0]));
        o_report.mask     = {(i_end_of_text ? open_bad : 6'b000000), closer_bad};
    end

    // Hold state; clear it on reset and after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_end_of_text)) begin
            r_brace   <= '0;
            r_bracket <= '0;
            r_paren   <= '0;
            r_str     <= 1'b0;
            r_lc      <= 1'b0;
            r_bc      <= 1'b0;
            r_slash   <= 1'b0;
            r_star    <= 1'b0;
            r_err     <= 1'b0;
            r_prev    <= '0;
            r_line    <= LINE_ONE;
            r_col     <= '0;
        end else if (i_accept) begin
            r_brace   <= n_brace;
            r_bracket <= n_bracket;
            r_paren   <= n_paren;
            r_str     <= n_str;
            r_lc      <= n_lc;
            r_bc      <= n_bc;
            r_slash   <= n_slash;
            r_star    <= n_star;
            r_err     <= n_err;
            r_prev    <= b;
            r_line    <= n_line;
            r_col     <= n_col;
        end
    end

endmodule

// ----- src/bbc_report_queue.sv -----
// Result register that hands out one report per beat from a byte's report set
module bbc_report_queue
    import bbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_report              i_report,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [3:0]           o_report_kind,
    output logic [LINE_BITS-1:0] o_line_number,
    output logic [COL_BITS-1:0]  o_column_number,
    output logic                 o_text_conforms,
    output logic                 o_last_report
);

    t_kind_mask           r_mask, n_mask, rest_mask;
    logic [LINE_BITS-1:0] r_line;
    logic [COL_BITS-1:0]  r_col;
    logic                 r_conf;
    t_kind                kind;
    logic                 pop;

    // Pick the lowest pending kind
    always_comb begin
        kind = KIND_CLOSE_BRACE;
        for (int i = NUM_KINDS - 1; i >= 0; i--) begin
            if (r_mask[i]) kind = t_kind'(i[KIND_BITS-1:0]);
        end
    end

    assign rest_mask       = r_mask & (r_mask - NUM_KINDS'(1));
    assign o_valid         = |r_mask;
    assign o_last_report   = (rest_mask == '0);
    assign pop             = o_valid && i_ready;
    assign o_room          = !o_valid || (o_last_report && i_ready);
    assign o_report_kind   = kind;
    assign o_line_number   = r_line;
    assign o_column_number = r_col;
    assign o_text_conforms = r_conf && (kind == KIND_SUMMARY);

    // Load a new set or drop the delivered report
    always_comb begin
        if (i_push) begin
            n_mask = i_report.mask;
        end else if (pop) begin
            n_mask = rest_mask;
        end else begin
            n_mask = r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_line <= i_report.line;
            r_col  <= i_report.col;
            r_conf <= i_report.conforms;
        end
    end

endmodule

// ----- src/bracket_balance_checker.sv -----
// Top level of the bracket balance checker
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | i_valid/o_ready, i_text_byte, end flag   | in
//  output  | o_valid/i_ready, kind, line, col, flags  | out
//
// One byte is taken per cycle while o_ready is high; its reports appear next cycle.
// A byte causes zero to five reports, delivered one per beat; the next
// byte is taken in the cycle the last report of the previous one leaves.
// The report register is the only stage between input and output.
// Synchronous active-low reset clears the scanner state and the pending reports.
// A stalled output holds the current report and blocks new bytes.
module bracket_balance_checker
    import bbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_text_byte,
    input  logic                 i_end_of_text,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [3:0]           o_report_kind,
    output logic [LINE_BITS-1:0] o_line_number,
    output logic [COL_BITS-1:0]  o_column_number,
    output logic                 o_text_conforms,
    output logic                 o_last_report
);

    t_report report;
    logic    accept;

    assign accept = i_valid && o_ready;

    // Lexer and counters
    bbc_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_report      (report)
    );

    // Report register and sequencer
    bbc_report_queue u_queue (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (accept),
        .i_report        (report),
        .o_room          (o_ready),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_report_kind   (o_report_kind),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number),
        .o_text_conforms (o_text_conforms),
        .o_last_report   (o_last_report)
    );

endmodule

// ----- src/bbc_checker.sv -----
// Port-level assertions for the bracket balance checker, bound to the top level
`include "bracket_balance_checker_assert.svh"

module bbc_checker
    import bbc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic [7:0]           i_text_byte,
    input logic                 i_end_of_text,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [3:0]           o_report_kind,
    input logic [LINE_BITS-1:0] o_line_number,
    input logic [COL_BITS-1:0]  o_column_number,
    input logic                 o_text_conforms,
    input logic                 o_last_report
);

    // Stalled report holds
    `BBC_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_report_kind))
    // Only a summary carries the conforms flag
    `BBC_ASSERT_NOW(a_conf_summary, o_valid && o_text_conforms, o_report_kind == KIND_SUMMARY)
    // Summary is always the last report of its byte
    `BBC_ASSERT_NOW(a_summary_last, o_valid && o_report_kind == KIND_SUMMARY, o_last_report)
    // No new byte while more than one report is pending
    `BBC_ASSERT_NOW(a_no_overrun, o_valid && !o_last_report, !o_ready)
    // Reset empties the report register
    `BBC_ASSERT_RST(a_reset_empty, !i_rst_n, !o_valid)

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (.*);
